// ===== rtl/mwc_pkg.sv =====
// Shared constants, operation codes and helpers for the lag-256 MWC generator.
// No dependencies; used by the top level and by its checker.
package mwc_pkg;

  // Lag table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Generator constants
  localparam logic [31:0] MWC_MULT   = 32'd809430660;
  localparam logic [31:0] CARRY_INIT = 32'd362436;
  localparam logic [31:0] LCG_MULT   = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;

  // Operation codes carried in tuser
  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_SEED = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  // One step of the seeding recurrence, modulo 2^32
  function automatic logic [31:0] lcg_next(input logic [31:0] s);
    logic [31:0] prod;
    prod = LCG_MULT * s;
    return prod + LCG_ADD;
  endfunction

endpackage

// ===== rtl/mwc_lag256_random_generator.sv =====
// Lag-256 multiply-with-carry generator: lag table in a one-port-write RAM,
// position and carry in registers. Depends on mwc_pkg.
//
// Draw: read the table word into a register, then multiply-add, write back and
//   load the output register; no new request is taken until the draw is done.
// Load: one table write, no result. Seed: 256 table writes, skipping zero values.
// Rate is set by the table RAM (registered read, then write-back) and the carry
//   chain. Synchronous active-low reset clears the table valid bits (table reads
//   as zero), sets position to 255 and carry to 362436.
module mwc_lag256_random_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] seed_value, [39:32] table_index
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] random_value
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SEED = 2'd2;

  localparam logic [mwc_pkg::IDX_W-1:0] LAST_IDX = mwc_pkg::IDX_W'(mwc_pkg::TABLE_DEPTH - 1);
  localparam logic [8:0] DEPTH_LIM = 9'(mwc_pkg::TABLE_DEPTH);

  logic [1:0]                  state_r;
  logic [mwc_pkg::IDX_W-1:0]   pos_r;
  logic [mwc_pkg::IDX_W-1:0]   pos_nxt;
  logic [mwc_pkg::IDX_W-1:0]   fill_r;
  logic [31:0]                 carry_r;
  logic [31:0]                 seed_r;
  logic [31:0]                 seed_nxt;
  logic                        out_tvalid_r;
  logic [31:0]                 out_tdata_r;

  logic [31:0]                 table_mem [mwc_pkg::TABLE_DEPTH];
  logic [mwc_pkg::TABLE_DEPTH-1:0] vld_r;
  logic [31:0]                 rd_data_r;
  logic                        rd_vld_r;

  logic [1:0]                  op;
  logic [31:0]                 word;
  logic [7:0]                  tidx;
  logic                        acc;
  logic                        rd_en;
  logic                        mul_go;
  logic [31:0]                 mul_word;
  logic [63:0]                 mac;
  logic                        wr_en;
  logic [mwc_pkg::IDX_W-1:0]   wr_addr;
  logic [31:0]                 wr_data;

  // Unpack the input transfer
  assign op   = in_tuser;
  assign word = in_tdata[31:0];
  assign tidx = in_tdata[39:32];

  assign in_tready  = (state_r == ST_IDLE);
  assign acc        = in_tvalid & in_tready;
  assign rd_en      = acc && (op == mwc_pkg::OP_DRAW);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Advance position modulo the table depth
  assign pos_nxt = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;

  // Multiply-add on the registered table word; hold while the output is full
  assign mul_go   = (state_r == ST_MUL) && (!out_tvalid_r || out_tready);
  assign mul_word = rd_vld_r ? rd_data_r : 32'd0;
  assign mac      = 64'(mul_word) * 64'(mwc_pkg::MWC_MULT) + 64'(carry_r);

  // Next seeding value
  assign seed_nxt = mwc_pkg::lcg_next(seed_r);

  // Single write port: draw write-back, seeding fill or single-word load
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = mac[31:0];
    if (mul_go) begin
      wr_en = 1'b1;
    end else if ((state_r == ST_SEED) && (seed_nxt != 32'd0)) begin
      wr_en   = 1'b1;
      wr_addr = fill_r;
      wr_data = seed_nxt;
    end else if (acc && (op == mwc_pkg::OP_LOAD) && ({1'b0, tidx} < DEPTH_LIM)) begin
      wr_en   = 1'b1;
      wr_addr = mwc_pkg::IDX_W'(tidx);
      wr_data = word;
    end
  end

  // Table RAM: registered read at the next position, one write per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= table_mem[pos_nxt];
      rd_vld_r  <= vld_r[pos_nxt];
    end
  end

  // Valid bits: cleared by reset, set by any table write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Sequencer, position, carry and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= LAST_IDX;
      carry_r      <= mwc_pkg::CARRY_INIT;
      fill_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Drop the result once the transfer completes
      if (mul_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            case (op)
              mwc_pkg::OP_DRAW: begin
                pos_r   <= pos_nxt;
                state_r <= ST_MUL;
              end
              mwc_pkg::OP_SEED: begin
                pos_r   <= LAST_IDX;
                carry_r <= mwc_pkg::CARRY_INIT;
                fill_r  <= '0;
                state_r <= ST_SEED;
              end
              mwc_pkg::OP_LOAD: begin
                pos_r   <= LAST_IDX;
                carry_r <= mwc_pkg::CARRY_INIT;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          if (mul_go) begin
            carry_r <= mac[63:32];
            state_r <= ST_IDLE;
          end
        end
        ST_SEED: begin
          // Skip zero values; finish after the last entry is filled
          if (seed_nxt != 32'd0) begin
            fill_r <= fill_r + 1'b1;
            if (fill_r == LAST_IDX) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: seeding word and output word
  always_ff @(posedge clk) begin
    if (acc && (op == mwc_pkg::OP_SEED)) begin
      seed_r <= word;
    end else if (state_r == ST_SEED) begin
      seed_r <= seed_nxt;
    end
    if (mul_go) begin
      out_tdata_r <= mac[31:0];
    end
  end

endmodule

// ===== rtl/mwc_chk.sv =====
// Port-level checker for the lag-256 MWC generator, bound to the top level.
// Depends on mwc_pkg for the operation codes.
module mwc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,   // [1:0] op
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata   // [31:0] random_value
);

  // Reset leaves an idle block with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("block not idle after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // A draw occupies the block for its multiply-add cycle
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == mwc_pkg::OP_DRAW)) |=> !in_tready)
    else $error("draw transfer did not hold off input");

  // Seeding holds off input while the table fills
  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == mwc_pkg::OP_SEED)) |=> ##1 !in_tready)
    else $error("seed transfer released input too early");

  // A load completes at once and gives no result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == mwc_pkg::OP_LOAD)) |=>
      (in_tready && !$rose(out_tvalid)))
    else $error("load transfer produced a result or stalled");

endmodule

bind mwc_lag256_random_generator mwc_chk u_mwc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
